// ----- design/ept_pkg.sv -----
// Shared types and constants for the encoder position tracker.
// Used by ept_pos_unit, encoder_position_tracker_core and ept_checker.
`default_nettype none

package ept_pkg;

    // field and register widths
    localparam int COUNT_VALUE_W = 16;
    localparam int CPR_W         = 16;
    localparam int DIAM_W        = 20;
    localparam int ROUND_W       = 32;
    localparam int PULSE_OUT_W   = 32;
    localparam int POS_W         = 48;
    localparam int S_TDATA_W     = 24;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 112;
    localparam int M_TUSER_W     = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 20;

    // parameter defaults
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int PULSE_WIDTH_DEF = 32;

    // behavior constants
    localparam int STEP_THRESHOLD   = 4;
    localparam int PULSES_PER_ROUND = 1000;
    localparam logic [CPR_W-1:0] CPR_RESET = 16'd1000;

    // pi in Q16, and the width of pi * diameter
    localparam int PI_W  = 18;
    localparam logic [PI_W-1:0] PI_Q16 = 18'd205887;
    localparam int A_W   = PI_W + DIAM_W;
    localparam int FRAC_W = 16;

    // position datapath sequencing
    localparam int CHUNK_W   = 16;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = POS_W / DIV_BITS;

    localparam logic [POS_W-1:0] POS_MAX_POS = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MAX_NEG = {1'b1, {(POS_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIAM     = 1'b1;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_INDEX   = 2'd1,
        REQ_CAPTURE = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_START,
        T_CALC,
        T_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_MUL,
        P_PREP,
        P_DIV,
        P_FIN
    } pos_state_t;

    typedef struct packed {
        logic             done;
        logic             clipped;
        logic [POS_W-1:0] position;
    } pos_rsp_t;

endpackage

`default_nettype wire

// ----- design/encoder_position_tracker_core.sv -----
// Encoder position tracker top level: event decode, counter state, output register.
// Depends on ept_pkg and ept_pos_unit.
`default_nettype none

// One word in, one word out. A count sample is returned after the position unit
// has run: it latches pi*diameter, passes each 16-bit chunk of the pulse count
// through the shared multiply-accumulate, and the 48 quotient bits leave the
// divider two per cycle; when the quotient overflows the divider is skipped.
// Index, capture and clear words go from T_IDLE straight to T_EMIT and are
// returned once the output register is free. s_tready is high only between words;
// the next word is taken while the previous result still waits on m_tready. A zero
// counts_per_rev gives position 0 with the clipped flag.
module encoder_position_tracker_core #(
    parameter int COUNT_WIDTH = ept_pkg::COUNT_WIDTH_DEF,
    parameter int PULSE_WIDTH = ept_pkg::PULSE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] count_value, [16] count_down, [23:17] zero
    input  wire logic [ept_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] req_type
    input  wire logic [ept_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [47:0] position_um, [79:48] pulse_total, [111:80] round_total
    output logic [ept_pkg::M_TDATA_W-1:0]          m_tdata,
    // [0] offset_already_set, [1] position_clipped
    output logic [ept_pkg::M_TUSER_W-1:0]          m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [ept_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ept_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int POS_W = ept_pkg::POS_W;

    ept_pkg::top_state_t state_reg, state_next;

    logic [ept_pkg::CPR_W-1:0]   cpr_reg;
    logic [ept_pkg::DIAM_W-1:0]  diam_reg;

    logic [COUNT_WIDTH-1:0]      latched_reg;
    logic                        dir_now_reg;
    logic                        dir_last_reg;
    logic [PULSE_WIDTH-1:0]      pulse_reg;
    logic [ept_pkg::ROUND_W-1:0] round_reg;
    logic [PULSE_WIDTH-1:0]      offset_reg;
    logic                        taken_reg;
    logic [POS_W-1:0]            position_reg;
    logic                        already_reg;
    logic                        clipped_reg;

    logic                          m_tvalid_reg;
    logic [POS_W-1:0]              out_pos_reg;
    logic [ept_pkg::PULSE_OUT_W-1:0] out_pulse_reg;
    logic [ept_pkg::ROUND_W-1:0]   out_round_reg;
    logic                          out_already_reg;
    logic                          out_clipped_reg;

    ept_pkg::req_t               req;
    logic                        accept;
    logic                        out_free;
    logic                        pos_start;
    logic                        load_out;
    ept_pkg::pos_rsp_t           rsp;

    logic [COUNT_WIDTH-1:0]      cnt_in;
    logic                        dir_in;
    logic [COUNT_WIDTH-1:0]      adiff;
    logic                        step_ok;
    logic [PULSE_WIDTH-1:0]      pulse_step;
    logic [ept_pkg::ROUND_W-1:0] round_new;
    logic [PULSE_WIDTH-1:0]      round_sx;
    logic [PULSE_WIDTH-1:0]      idx_mul;
    logic [PULSE_WIDTH-1:0]      pulse_idx;

    ept_pos_unit #(
        .PULSE_WIDTH (PULSE_WIDTH)
    ) u_pos_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pos_start),
        .pulse (pulse_reg),
        .cpr   (cpr_reg),
        .diam  (diam_reg),
        .rsp   (rsp)
    );

    assign req      = ept_pkg::req_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // sample decode
    assign cnt_in     = COUNT_WIDTH'(s_tdata[ept_pkg::COUNT_VALUE_W-1:0]);
    assign dir_in     = s_tdata[ept_pkg::COUNT_VALUE_W];
    assign adiff      = (cnt_in > latched_reg) ? (cnt_in - latched_reg)
                                               : (latched_reg - cnt_in);
    assign step_ok    = adiff >= COUNT_WIDTH'(ept_pkg::STEP_THRESHOLD);
    assign pulse_step = dir_in ? (pulse_reg - 1'b1) : (pulse_reg + 1'b1);

    // index: step cancels when the direction flipped since the last index or offset capture
    always_comb
    begin
        if (dir_last_reg == dir_now_reg)
        begin
            round_new = dir_now_reg ? (round_reg - 1'b1) : (round_reg + 1'b1);
        end
        else
        begin
            round_new = round_reg;
        end
    end

    assign round_sx  = PULSE_WIDTH'(signed'(round_new));
    assign idx_mul   = round_sx * PULSE_WIDTH'(ept_pkg::PULSES_PER_ROUND);
    assign pulse_idx = idx_mul + offset_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ept_pkg::T_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (req == ept_pkg::REQ_SAMPLE) ? ept_pkg::T_START
                                                              : ept_pkg::T_EMIT;
                end
            end
            ept_pkg::T_START:
            begin
                state_next = ept_pkg::T_CALC;
            end
            ept_pkg::T_CALC:
            begin
                if (rsp.done)
                begin
                    state_next = ept_pkg::T_EMIT;
                end
            end
            ept_pkg::T_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ept_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = ept_pkg::T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ept_pkg::T_IDLE);
        pos_start = (state_reg == ept_pkg::T_START);
        load_out  = (state_reg == ept_pkg::T_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ept_pkg::T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= ept_pkg::CPR_RESET;
            diam_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ept_pkg::CFG_COUNTS_PER_REV:
                begin
                    cpr_reg <= cfg_data[ept_pkg::CPR_W-1:0];
                end
                ept_pkg::CFG_WHEEL_DIAM:
                begin
                    diam_reg <= cfg_data;
                end
                default:
                begin
                    cpr_reg <= cpr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg  <= '0;
            dir_now_reg  <= 1'b0;
            dir_last_reg <= 1'b0;
            pulse_reg    <= '0;
            round_reg    <= '0;
            offset_reg   <= '0;
            taken_reg    <= 1'b0;
            position_reg <= '0;
            already_reg  <= 1'b0;
            clipped_reg  <= 1'b0;
        end
        else if (accept)
        begin
            // a capture with the offset already held only raises the flag
            already_reg <= (req == ept_pkg::REQ_CAPTURE) && taken_reg;
            clipped_reg <= 1'b0;
            unique case (req)
                ept_pkg::REQ_SAMPLE:
                begin
                    dir_now_reg <= dir_in;
                    if (step_ok)
                    begin
                        pulse_reg   <= pulse_step;
                        latched_reg <= cnt_in;
                    end
                end
                ept_pkg::REQ_INDEX:
                begin
                    round_reg    <= round_new;
                    dir_last_reg <= dir_now_reg;
                    pulse_reg    <= pulse_idx;
                end
                ept_pkg::REQ_CAPTURE:
                begin
                    if (!taken_reg)
                    begin
                        offset_reg   <= pulse_reg;
                        dir_last_reg <= dir_now_reg;
                        taken_reg    <= 1'b1;
                    end
                end
                ept_pkg::REQ_CLEAR:
                begin
                    latched_reg  <= '0;
                    dir_now_reg  <= 1'b0;
                    dir_last_reg <= 1'b0;
                    pulse_reg    <= '0;
                    round_reg    <= '0;
                    offset_reg   <= '0;
                    taken_reg    <= 1'b0;
                    position_reg <= '0;
                end
            endcase
        end
        else if ((state_reg == ept_pkg::T_CALC) && rsp.done)
        begin
            position_reg <= rsp.position;
            clipped_reg  <= rsp.clipped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pos_reg     <= position_reg;
            out_pulse_reg   <= ept_pkg::PULSE_OUT_W'(pulse_reg);
            out_round_reg   <= round_reg;
            out_already_reg <= already_reg;
            out_clipped_reg <= clipped_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_round_reg, out_pulse_reg, out_pos_reg};
    assign m_tuser  = {out_clipped_reg, out_already_reg};

endmodule

`default_nettype wire

// ----- design/ept_pos_unit.sv -----
// Iterative position unit: pi*diameter*pulse / (counts_per_rev * 2^16).
// Shared 16-bit-chunk multiply-accumulate, then a radix-4 restoring divider.
// Depends on ept_pkg.
`default_nettype none

module ept_pos_unit #(
    parameter int PULSE_WIDTH = ept_pkg::PULSE_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [PULSE_WIDTH-1:0]      pulse,
    input  wire logic [ept_pkg::CPR_W-1:0]   cpr,
    input  wire logic [ept_pkg::DIAM_W-1:0]  diam,
    output ept_pkg::pos_rsp_t                rsp
);

    localparam int N_CHUNK = (PULSE_WIDTH + ept_pkg::CHUNK_W - 1) / ept_pkg::CHUNK_W;
    localparam int MAG_W   = N_CHUNK * ept_pkg::CHUNK_W;
    localparam int PROD_W  = ept_pkg::A_W + PULSE_WIDTH;
    localparam int DIV_W   = PROD_W - ept_pkg::FRAC_W;
    localparam int EXT_W   = (DIV_W > ept_pkg::POS_W) ? DIV_W : ept_pkg::POS_W + 1;
    localparam int HI_W    = EXT_W - ept_pkg::POS_W;
    localparam int CMP_W   = HI_W + ept_pkg::CPR_W;
    localparam int PP_W    = ept_pkg::A_W + ept_pkg::CHUNK_W;
    localparam int CH_W    = $clog2(N_CHUNK + 1);
    localparam int STEP_W  = $clog2(ept_pkg::DIV_STEPS + 1);
    localparam int POS_W   = ept_pkg::POS_W;
    localparam int CPR_W   = ept_pkg::CPR_W;

    ept_pkg::pos_state_t state_reg, state_next;

    logic [ept_pkg::A_W-1:0] a_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic                    zdiv_reg;
    logic                    over_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [CH_W-1:0]         chunk_cnt_reg;
    logic [CPR_W-1:0]        rem_reg;
    logic [POS_W-1:0]        dlo_reg;
    logic [POS_W-1:0]        q_reg;
    logic [STEP_W-1:0]       step_reg;

    logic                    ld_start, mul_en, prep_en, div_en;

    logic [PULSE_WIDTH-1:0]  mag_in;
    logic [ept_pkg::A_W-1:0] a_in;
    logic [ept_pkg::CHUNK_W-1:0] chunk;
    logic [PP_W-1:0]         pp;
    logic [PROD_W-1:0]       acc_next;
    logic [EXT_W-1:0]        dext;
    logic [HI_W-1:0]         hi;
    logic                    over_in;
    logic [CPR_W:0]          t1, t2;
    logic                    ge1, ge2;
    logic [CPR_W-1:0]        r1, r2;
    logic                    clip_fin;
    logic [POS_W-1:0]        qsat;

    // operand setup
    assign mag_in = pulse[PULSE_WIDTH-1] ? (~pulse + 1'b1) : pulse;
    assign a_in   = ept_pkg::A_W'(ept_pkg::PI_Q16) * ept_pkg::A_W'(diam);

    // multiply: top chunk first, accumulator shifts up one chunk per cycle
    assign chunk    = mag_reg[MAG_W-1 -: ept_pkg::CHUNK_W];
    assign pp       = PP_W'(a_reg) * PP_W'(chunk);
    assign acc_next = (acc_reg << ept_pkg::CHUNK_W) + PROD_W'(pp);

    // quotient bits above the 48-bit result only flag overflow
    assign dext    = EXT_W'(acc_reg[PROD_W-1:ept_pkg::FRAC_W]);
    assign hi      = dext[EXT_W-1:POS_W];
    assign over_in = CMP_W'(hi) >= CMP_W'(cpr);

    // two restoring steps per cycle
    always_comb
    begin
        t1  = {rem_reg, dlo_reg[POS_W-1]};
        ge1 = t1 >= {1'b0, cpr};
        r1  = ge1 ? CPR_W'(t1 - {1'b0, cpr}) : t1[CPR_W-1:0];
        t2  = {r1, dlo_reg[POS_W-2]};
        ge2 = t2 >= {1'b0, cpr};
        r2  = ge2 ? CPR_W'(t2 - {1'b0, cpr}) : t2[CPR_W-1:0];
    end

    // saturation and sign
    always_comb
    begin
        if (neg_reg)
        begin
            clip_fin = over_reg || (q_reg > ept_pkg::POS_MAX_NEG);
            qsat     = clip_fin ? ept_pkg::POS_MAX_NEG : q_reg;
        end
        else
        begin
            clip_fin = over_reg || (q_reg > ept_pkg::POS_MAX_POS);
            qsat     = clip_fin ? ept_pkg::POS_MAX_POS : q_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ept_pkg::P_IDLE:
            begin
                if (start)
                begin
                    state_next = (cpr == '0) ? ept_pkg::P_FIN : ept_pkg::P_MUL;
                end
            end
            ept_pkg::P_MUL:
            begin
                if (chunk_cnt_reg == '0)
                begin
                    state_next = ept_pkg::P_PREP;
                end
            end
            ept_pkg::P_PREP:
            begin
                state_next = over_in ? ept_pkg::P_FIN : ept_pkg::P_DIV;
            end
            ept_pkg::P_DIV:
            begin
                if (step_reg == STEP_W'(ept_pkg::DIV_STEPS - 1))
                begin
                    state_next = ept_pkg::P_FIN;
                end
            end
            ept_pkg::P_FIN:
            begin
                state_next = ept_pkg::P_IDLE;
            end
            default:
            begin
                state_next = ept_pkg::P_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ld_start     = (state_reg == ept_pkg::P_IDLE) && start;
        mul_en       = (state_reg == ept_pkg::P_MUL);
        prep_en      = (state_reg == ept_pkg::P_PREP);
        div_en       = (state_reg == ept_pkg::P_DIV);
        rsp.done     = (state_reg == ept_pkg::P_FIN);
        rsp.clipped  = zdiv_reg || clip_fin;
        if (zdiv_reg)
        begin
            rsp.position = '0;
        end
        else if (neg_reg)
        begin
            rsp.position = ~qsat + 1'b1;
        end
        else
        begin
            rsp.position = qsat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ept_pkg::P_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_start)
        begin
            a_reg         <= a_in;
            mag_reg       <= MAG_W'(mag_in);
            neg_reg       <= pulse[PULSE_WIDTH-1];
            zdiv_reg      <= (cpr == '0);
            over_reg      <= 1'b0;
            acc_reg       <= '0;
            chunk_cnt_reg <= CH_W'(N_CHUNK - 1);
        end
        if (mul_en)
        begin
            acc_reg       <= acc_next;
            mag_reg       <= mag_reg << ept_pkg::CHUNK_W;
            chunk_cnt_reg <= chunk_cnt_reg - 1'b1;
        end
        if (prep_en)
        begin
            over_reg <= over_in;
            rem_reg  <= CPR_W'(hi);
            dlo_reg  <= dext[POS_W-1:0];
            q_reg    <= '0;
            step_reg <= '0;
        end
        if (div_en)
        begin
            rem_reg  <= r2;
            dlo_reg  <= dlo_reg << ept_pkg::DIV_BITS;
            q_reg    <= {q_reg[POS_W-3:0], ge1, ge2};
            step_reg <= step_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- design/ept_checker.sv -----
// Port-level checks for encoder_position_tracker_core, attached by bind.
// Depends on ept_pkg.
`default_nettype none

module ept_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ept_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [ept_pkg::M_TUSER_W-1:0] m_tuser
);

    // one word in flight: no back-to-back accepts
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // capture and sample flags never on the same word
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("already-set and clipped both high");

    // clipped position is a rail or zero
    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |->
            ((m_tdata[ept_pkg::POS_W-1:0] == ept_pkg::POS_MAX_POS) ||
             (m_tdata[ept_pkg::POS_W-1:0] == ept_pkg::POS_MAX_NEG) ||
             (m_tdata[ept_pkg::POS_W-1:0] == '0)))
        else $error("clipped position off the rails");

endmodule

bind encoder_position_tracker_core ept_checker u_ept_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- dv/tb_encoder_position_tracker_core.sv -----
// Self-checking testbench for encoder_position_tracker_core: directed table, then random bursts.
// Depends on ept_pkg and the RTL under design/; expected words come from the directed table or an in-bench predictor.

module tb_encoder_position_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [47:0] pos_um;
        logic [31:0] pulses;
        logic [31:0] rounds;
        logic        already;
        logic        clipped;
    } reading_t;

    typedef struct packed {
        logic          wr_cpr;
        logic          wr_diam;
        logic [15:0]   cpr;
        logic [19:0]   diam;
        ept_pkg::req_t req;
        logic [15:0]   cnt;
        logic          down;
        logic          typed;
        reading_t      want;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ept_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [ept_pkg::S_TUSER_W-1:0]  s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ept_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [ept_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                           cfg_we;
    logic [ept_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ept_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block state and registers
    logic [15:0] cpr_set;
    logic [19:0] diam_set;
    logic [15:0] cnt_latched;
    logic        dir_cur;
    logic        dir_idx;
    logic [31:0] pulse_acc;
    logic [31:0] round_acc;
    logic [31:0] offset_cap;
    logic        offset_held;
    logic [47:0] pos_held;

    reading_t  pending_readings[$];
    reading_t  seen_word;
    reading_t  next_want;
    reading_t  predicted;
    logic      word_typed;
    reading_t  word_want;
    stim_row_t dir_rows[$];

    int        mismatch_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        items_sent;
    logic [15:0] walk_cnt;

    encoder_position_tracker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // pi * diameter * pulses / (cpr * 2^16), truncated toward zero, saturated to 48 bits
    function automatic logic [47:0] travel_from_pulses(input logic [31:0] pulses,
                                                       output logic clip);
        logic [31:0]  mag;
        logic [127:0] prod;
        logic [127:0] divisor;
        logic [127:0] quot;
        clip = 1'b0;
        if (cpr_set == 16'd0)
        begin
            clip = 1'b1;
            return 48'd0;
        end
        mag = pulses[31] ? (32'd0 - pulses) : pulses;
        prod = 128'(ept_pkg::PI_Q16) * 128'(diam_set) * 128'(mag);
        divisor = 128'({cpr_set, 16'h0000});
        quot = prod / divisor;
        if (pulses[31])
        begin
            if (quot > 128'(ept_pkg::POS_MAX_NEG))
            begin
                clip = 1'b1;
                quot = 128'(ept_pkg::POS_MAX_NEG);
            end
            return 48'd0 - quot[47:0];
        end
        if (quot > 128'(ept_pkg::POS_MAX_POS))
        begin
            clip = 1'b1;
            quot = 128'(ept_pkg::POS_MAX_POS);
        end
        return quot[47:0];
    endfunction

    function automatic reading_t advance_tracker(input ept_pkg::req_t req,
                                                 input logic [15:0] cnt,
                                                 input logic down);
        reading_t    r;
        logic [15:0] diff;
        logic        clip;
        r = '0;
        case (req)
            ept_pkg::REQ_SAMPLE:
            begin
                dir_cur = down;
                diff = (cnt > cnt_latched) ? cnt - cnt_latched : cnt_latched - cnt;
                if (diff >= 16'(ept_pkg::STEP_THRESHOLD))
                begin
                    pulse_acc = dir_cur ? pulse_acc - 32'd1 : pulse_acc + 32'd1;
                    cnt_latched = cnt;
                end
                pos_held = travel_from_pulses(pulse_acc, clip);
                r.clipped = clip;
            end
            ept_pkg::REQ_INDEX:
            begin
                // a direction change since the last index or offset capture cancels this step
                if (dir_idx == dir_cur)
                    round_acc = dir_cur ? round_acc - 32'd1 : round_acc + 32'd1;
                dir_idx = dir_cur;
                pulse_acc = round_acc * 32'(ept_pkg::PULSES_PER_ROUND) + offset_cap;
            end
            ept_pkg::REQ_CAPTURE:
            begin
                if (!offset_held)
                begin
                    offset_cap = pulse_acc;
                    dir_idx = dir_cur;
                    offset_held = 1'b1;
                end
                else
                    r.already = 1'b1;
            end
            default:
            begin
                cnt_latched = '0;
                dir_cur = 1'b0;
                dir_idx = 1'b0;
                pulse_acc = '0;
                round_acc = '0;
                offset_cap = '0;
                offset_held = 1'b0;
                pos_held = '0;
            end
        endcase
        r.pos_um = pos_held;
        r.pulses = pulse_acc;
        r.rounds = round_acc;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_reading(input reading_t got, input reading_t want);
        if (got.pos_um !== want.pos_um)
            report_mismatch("position_um", 64'(got.pos_um), 64'(want.pos_um));
        if (got.pulses !== want.pulses)
            report_mismatch("pulse_total", 64'(got.pulses), 64'(want.pulses));
        if (got.rounds !== want.rounds)
            report_mismatch("round_total", 64'(got.rounds), 64'(want.rounds));
        if (got.already !== want.already)
            report_mismatch("offset_already_set", 64'(got.already), 64'(want.already));
        if (got.clipped !== want.clipped)
            report_mismatch("position_clipped", 64'(got.clipped), 64'(want.clipped));
    endtask

    // result check first, so a word leaving on the same edge pairs with the older item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_word.pos_um = m_tdata[47:0];
                seen_word.pulses = m_tdata[79:48];
                seen_word.rounds = m_tdata[111:80];
                seen_word.already = m_tuser[0];
                seen_word.clipped = m_tuser[1];
                if (pending_readings.size() == 0)
                    report_mismatch("word with nothing pending", 64'd0, 64'd0);
                else
                begin
                    next_want = pending_readings.pop_front();
                    check_reading(seen_word, next_want);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted = advance_tracker(ept_pkg::req_t'(s_tuser), s_tdata[15:0],
                                            s_tdata[16]);
                pending_readings.push_back(word_typed ? word_want : predicted);
            end
        end
    end

    // called at a falling edge, returns at a falling edge with s_tvalid still high
    task automatic send_word(input ept_pkg::req_t req, input logic [15:0] cnt,
                             input logic down, input logic typed, input reading_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, down, cnt};
        s_tuser <= req;
        word_typed = typed;
        word_want = want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_plain(input ept_pkg::req_t req, input logic [15:0] cnt,
                              input logic down);
        send_word(req, cnt, down, 1'b0, '0);
    endtask

    task automatic drain_results();
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // only while idle: stop offering words, let every result out, then write
    task automatic apply_config(input logic wr_cpr, input logic wr_diam,
                                input logic [15:0] cpr, input logic [19:0] diam);
        s_tvalid <= 1'b0;
        @(negedge clk);
        drain_results();
        if (wr_cpr)
        begin
            cfg_we <= 1'b1;
            cfg_index <= ept_pkg::CFG_COUNTS_PER_REV;
            cfg_data <= 20'(cpr);
            cpr_set = cpr;
            @(negedge clk);
        end
        if (wr_diam)
        begin
            cfg_we <= 1'b1;
            cfg_index <= ept_pkg::CFG_WHEEL_DIAM;
            cfg_data <= diam;
            diam_set = diam;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic stim_row_t stim_entry(logic wr_cpr, logic wr_diam, logic [15:0] cpr,
                                             logic [19:0] diam, ept_pkg::req_t req,
                                             logic [15:0] cnt, logic down, logic typed,
                                             logic [31:0] pulses, logic [31:0] rounds,
                                             logic already, logic clipped);
        stim_row_t e;
        e.wr_cpr = wr_cpr;
        e.wr_diam = wr_diam;
        e.cpr = cpr;
        e.diam = diam;
        e.req = req;
        e.cnt = cnt;
        e.down = down;
        e.typed = typed;
        e.want.pos_um = 48'd0;
        e.want.pulses = pulses;
        e.want.rounds = rounds;
        e.want.already = already;
        e.want.clipped = clipped;
        return e;
    endfunction

    task automatic random_burst();
        int          pick;
        int          n;
        logic        d;
        logic [15:0] delta;
        pick = $urandom_range(99);
        d = 1'($urandom_range(1));
        if (pick < 35)
        begin
            // encoder walk: small steps in one direction, some below the step threshold
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                delta = 16'($urandom_range(9));
                walk_cnt = d ? walk_cnt - delta : walk_cnt + delta;
                send_plain(ept_pkg::REQ_SAMPLE, walk_cnt, ($urandom_range(9) == 0) ? ~d : d);
            end
        end
        else if (pick < 60)
        begin
            // run of index pulses in one direction, framed by samples
            walk_cnt = 16'($urandom);
            send_plain(ept_pkg::REQ_SAMPLE, walk_cnt, d);
            n = $urandom_range(1, 40);
            repeat (n)
                send_plain(ept_pkg::REQ_INDEX, 16'($urandom), 1'($urandom));
            walk_cnt = walk_cnt ^ 16'h0100;
            send_plain(ept_pkg::REQ_SAMPLE, walk_cnt, d);
        end
        else if (pick < 70)
            send_plain(ept_pkg::REQ_CAPTURE, 16'($urandom), 1'($urandom));
        else if (pick < 73)
            send_plain(ept_pkg::REQ_CLEAR, 16'($urandom), 1'($urandom));
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_plain(ept_pkg::req_t'($urandom_range(3)), 16'($urandom),
                           1'($urandom));
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_encoder_position_tracker_core NOT OK");
        $finish;
    end

    initial
    begin
        int target;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        word_typed = 1'b0;
        word_want = '0;
        mismatch_count = 0;
        items_sent = 0;
        walk_cnt = '0;
        tx_idle_pct = 24;
        rx_idle_pct = 79;
        cpr_set = ept_pkg::CPR_RESET;
        diam_set = '0;
        void'(advance_tracker(ept_pkg::REQ_CLEAR, 16'd0, 1'b0));

        // reset values first, then zero resolution, extremes and a full clear
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h0000,
                                      1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h0003,
                                      1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h0004,
                                      1'b0, 1'b1, 32'd1, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'hFFFF,
                                      1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'hFFFC,
                                      1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h0000,
                                      1'b1, 1'b1, 32'hFFFF_FFFF, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_INDEX, 16'h0000,
                                      1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_INDEX, 16'h0000,
                                      1'b0, 1'b1, 32'hFFFF_FC18, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_CAPTURE, 16'h0000,
                                      1'b0, 1'b1, 32'hFFFF_FC18, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_CAPTURE, 16'hFFFF,
                                      1'b1, 1'b1, 32'hFFFF_FC18, 32'hFFFF_FFFF, 1'b1, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'd100,
                                      1'b0, 1'b1, 32'hFFFF_FC19, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_INDEX, 16'h0000,
                                      1'b0, 1'b1, 32'hFFFF_F830, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_INDEX, 16'h0000,
                                      1'b0, 1'b1, 32'hFFFF_FC18, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_CLEAR, 16'hFFFF,
                                      1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b1, '0, 20'hFFFFF, ept_pkg::REQ_SAMPLE,
                                      16'h0004, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b1, 1'b0, 16'd0, '0, ept_pkg::REQ_SAMPLE, 16'h0008,
                                      1'b1, 1'b1, '0, '0, 1'b0, 1'b1));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h0000,
                                      1'b1, 1'b1, 32'hFFFF_FFFF, '0, 1'b0, 1'b1));
        dir_rows.push_back(stim_entry(1'b1, 1'b1, 16'hFFFF, 20'hFFFFF, ept_pkg::REQ_SAMPLE,
                                      16'hFFFF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h7FFF,
                                      1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b1, 1'b1, 16'd1, 20'hFFFFF, ept_pkg::REQ_INDEX,
                                      16'h0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_INDEX, 16'h0000,
                                      1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h0004,
                                      1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_CAPTURE, 16'h0000,
                                      1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_CLEAR, 16'h0000,
                                      1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(stim_entry(1'b0, 1'b0, '0, '0, ept_pkg::REQ_SAMPLE, 16'h5555,
                                      1'b0, 1'b0, '0, '0, 1'b0, 1'b0));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr_cpr || dir_rows[i].wr_diam)
                apply_config(dir_rows[i].wr_cpr, dir_rows[i].wr_diam,
                             dir_rows[i].cpr, dir_rows[i].diam);
            send_word(dir_rows[i].req, dir_rows[i].cnt, dir_rows[i].down,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        // six phases of random bursts, each with its own register setting; the idle mix changes every two phases
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: apply_config(1'b1, 1'b1, 16'd1000, 20'($urandom));
                1: apply_config(1'b1, 1'b1, 16'd1, 20'hFFFFF);
                2: apply_config(1'b1, 1'b1, 16'hFFFF, 20'd0);
                3: apply_config(1'b1, 1'b1, 16'd0, 20'($urandom));
                4: apply_config(1'b1, 1'b1, 16'($urandom_range(2, 64)), 20'hFFFFF);
                default: apply_config(1'b1, 1'b1, 16'($urandom), 20'($urandom));
            endcase
            if (ph < 2)
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 79;
            end
            else if (ph < 4)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 24;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            target = items_sent + 190;
            while (items_sent < target)
                random_burst();
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        drain_results();
        if (mismatch_count == 0)
            $display("tb_encoder_position_tracker_core OK");
        else
            $display("tb_encoder_position_tracker_core NOT OK");
        $finish;
    end

endmodule
